[design/ucal_pkg.sv]
// Shared types, constants and month table for the seconds-to-calendar converter.
`default_nettype none

package ucal_pkg;

  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned EpochYear   = 1970;

  localparam int unsigned DayQuoBits  = 16;  // days since epoch < 2^16
  localparam int unsigned HourQuoBits = 5;
  localparam int unsigned MinQuoBits  = 6;

  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthDec = 4'd12;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DAY,
    S_HOUR,
    S_MIN,
    S_YEAR,
    S_MONTH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] acc;
    logic [31:0] opnd;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] diff;
    logic        ge;
  } alu_rsp_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_t;

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

[design/ucal_alu.sv]
// Shared compare-and-subtract unit used by every step of the converter.
`default_nettype none

module ucal_alu
  import ucal_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [32:0] wide;

  assign wide     = {1'b0, req.acc} - {1'b0, req.opnd};
  assign rsp.diff = wide[31:0];
  assign rsp.ge   = ~wide[32];

endmodule

`default_nettype wire

[design/ucal_seq.sv]
// Sequencer and working registers: divisions, year walk and month walk.
`default_nettype none

module ucal_seq
  import ucal_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] secs,
  input  logic        take,
  output logic        idle,
  output logic        res_valid,
  output cal_t        res,
  output alu_req_t    alu_req,
  input  alu_rsp_t    alu_rsp
);

  state_t      state, state_next;
  logic [31:0] acc, acc_next;
  logic [31:0] dvs, dvs_next;
  logic [3:0]  cnt, cnt_next;
  logic [15:0] quo, quo_next;
  logic [15:0] days, days_next;
  logic [6:0]  ym100, ym100_next;  // year mod 100
  logic [8:0]  ym400, ym400_next;  // year mod 400
  cal_t        cal, cal_next;

  logic [31:0] step_acc;
  logic [15:0] step_quo;
  logic        leap;

  assign leap = (cal.year[1:0] == 2'd0) && ((ym100 != 7'd0) || (ym400 == 9'd0));

  always_comb begin
    alu_req.acc = acc;
    case (state)
      S_YEAR:  alu_req.opnd = leap ? 32'd366 : 32'd365;
      S_MONTH: alu_req.opnd = 32'(month_days(cal.month, leap));
      default: alu_req.opnd = dvs;
    endcase
  end

  assign step_acc = alu_rsp.ge ? alu_rsp.diff : acc;
  assign step_quo = {quo[14:0], alu_rsp.ge};

  always_comb begin
    state_next = state;
    acc_next   = acc;
    dvs_next   = dvs >> 1;
    cnt_next   = cnt - 4'd1;
    quo_next   = step_quo;
    days_next  = days;
    ym100_next = ym100;
    ym400_next = ym400;
    cal_next   = cal;
    case (state)
      S_IDLE: begin
        if (start) begin
          acc_next   = secs;
          dvs_next   = 32'(SecsPerDay) << (DayQuoBits - 1);
          cnt_next   = 4'(DayQuoBits - 1);
          quo_next   = '0;
          state_next = S_DAY;
        end
      end
      S_DAY: begin
        acc_next = step_acc;
        if (cnt == 4'd0) begin
          days_next  = step_quo;
          dvs_next   = 32'(SecsPerHour) << (HourQuoBits - 1);
          cnt_next   = 4'(HourQuoBits - 1);
          quo_next   = '0;
          state_next = S_HOUR;
        end
      end
      S_HOUR: begin
        acc_next = step_acc;
        if (cnt == 4'd0) begin
          cal_next.hour = step_quo[4:0];
          dvs_next      = 32'(SecsPerMin) << (MinQuoBits - 1);
          cnt_next      = 4'(MinQuoBits - 1);
          quo_next      = '0;
          state_next    = S_MIN;
        end
      end
      S_MIN: begin
        acc_next = step_acc;
        if (cnt == 4'd0) begin
          cal_next.minute = step_quo[5:0];
          cal_next.second = step_acc[5:0];
          acc_next        = 32'(days);
          cal_next.year   = 12'(EpochYear);
          ym100_next      = 7'(EpochYear % 100);
          ym400_next      = 9'(EpochYear % 400);
          state_next      = S_YEAR;
        end
      end
      S_YEAR: begin
        if (alu_rsp.ge) begin
          acc_next      = alu_rsp.diff;
          cal_next.year = cal.year + 12'd1;
          ym100_next    = (ym100 == 7'd99)  ? 7'd0 : ym100 + 7'd1;
          ym400_next    = (ym400 == 9'd399) ? 9'd0 : ym400 + 9'd1;
        end else begin
          cal_next.month = MonthJan;
          state_next     = S_MONTH;
        end
      end
      S_MONTH: begin
        if (alu_rsp.ge && (cal.month != MonthDec)) begin
          acc_next       = alu_rsp.diff;
          cal_next.month = cal.month + 4'd1;
        end else begin
          cal_next.day = acc[4:0] + 5'd1;
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        if (take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    acc   <= acc_next;
    dvs   <= dvs_next;
    cnt   <= cnt_next;
    quo   <= quo_next;
    days  <= days_next;
    ym100 <= ym100_next;
    ym400 <= ym400_next;
    cal   <= cal_next;
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = cal;

endmodule

`default_nettype wire

[design/unix_seconds_to_calendar_top.sv]
// Top level: seconds since 1970 to Gregorian date and time of day.
//
// Input channel: in_valid/in_ready with seconds_since_epoch (unsigned, 32 bits).
// Output channel: out_valid/out_ready with year_out, month_out, day_out,
// hour_out, minute_out, second_out. One result per request.
//
// One compare-and-subtract unit does all the arithmetic under a small sequencer:
//   16 steps  divide by 86400 (days, seconds of day)
//    5 steps  divide by 3600  (hour)
//    6 steps  divide by 60    (minute, second)
//   up to 137 year steps, up to 12 month steps, plus one start and one hand-off.
// in_ready is high only while the sequencer is idle; one request is worked on
// at a time.
//
// The finished result moves into an output register, so the next request can
// be taken while the receiver stalls. If the register is still full when the
// next result completes, that result waits in the sequencer until it drains.
// Synchronous reset empties the output register and idles the sequencer.
`default_nettype none

module unix_seconds_to_calendar_top
  import ucal_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] seconds_since_epoch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] year_out,
  output logic [3:0]  month_out,
  output logic [4:0]  day_out,
  output logic [4:0]  hour_out,
  output logic [5:0]  minute_out,
  output logic [5:0]  second_out
);

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  cal_t     res;
  cal_t     held;
  logic     idle;
  logic     res_valid;
  logic     take;

  // Output register is free when empty or being drained this cycle.
  assign take     = res_valid && (!out_valid || out_ready);
  assign in_ready = idle;

  ucal_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  ucal_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && in_ready),
    .secs      (seconds_since_epoch),
    .take      (take),
    .idle      (idle),
    .res_valid (res_valid),
    .res       (res),
    .alu_req   (alu_req),
    .alu_rsp   (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    if (take) begin
      held <= res;
    end
  end

  assign year_out   = held.year;
  assign month_out  = held.month;
  assign day_out    = held.day;
  assign hour_out   = held.hour;
  assign minute_out = held.minute;
  assign second_out = held.second;

endmodule

`default_nettype wire

[design/ucal_checker.sv]
// Port-level checks for the converter, bound to the top level.
`default_nettype none

module ucal_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] year_out,
  input logic [3:0]  month_out,
  input logic [4:0]  day_out,
  input logic [4:0]  hour_out,
  input logic [5:0]  minute_out,
  input logic [5:0]  second_out
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(year_out) && $stable(day_out))
    else $error("stalled result dropped or changed");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result present straight after reset");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> year_out >= 12'd1970 && year_out <= 12'd2106 &&
                  month_out >= 4'd1 && month_out <= 4'd12 &&
                  day_out >= 5'd1)
    else $error("date out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hour_out <= 5'd23 && minute_out <= 6'd59 && second_out <= 6'd59)
    else $error("time of day out of range");

endmodule

bind unix_seconds_to_calendar_top ucal_checker u_ucal_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .year_out   (year_out),
  .month_out  (month_out),
  .day_out    (day_out),
  .hour_out   (hour_out),
  .minute_out (minute_out),
  .second_out (second_out)
);

`default_nettype wire

[tb/unix_seconds_to_calendar_top_tb.sv]
// Self-checking testbench for the seconds-to-calendar converter.
module unix_seconds_to_calendar_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ucal_pkg::*;

  // Run sizing. The watchdog limit sits well above the time one request takes in
  // the block plus the longest gap of the sender and the longest span in which
  // the receiver holds ready low.
  localparam int RandomRequests = 1300;
  localparam int WatchdogLimit  = 5000;
  localparam int DrainCycles    = 200;
  localparam int MaxReported    = 10;
  localparam int NumProbes      = 20;

  localparam int unsigned DaysInMonth [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // One row of the directed table. Where known is set, the date is typed in and
  // checked as it stands; otherwise the predictor supplies it.
  typedef struct packed {
    logic [31:0] secs;
    logic        known;
    cal_t        date;
  } probe_t;

  localparam probe_t Probes [NumProbes] = '{
    '{32'd0,          1'b1, '{12'd1970, MonthJan, 5'd1,  5'd0,  6'd0,  6'd0}},
    '{32'd59,         1'b0, '0},
    '{32'd60,         1'b0, '0},
    '{32'd3599,       1'b0, '0},
    '{32'd3600,       1'b0, '0},
    '{32'd86399,      1'b1, '{12'd1970, MonthJan, 5'd1,  5'd23, 6'd59, 6'd59}},
    '{32'd86400,      1'b1, '{12'd1970, MonthJan, 5'd2,  5'd0,  6'd0,  6'd0}},
    '{32'd31535999,   1'b1, '{12'd1970, MonthDec, 5'd31, 5'd23, 6'd59, 6'd59}},
    '{32'd31536000,   1'b1, '{12'd1971, MonthJan, 5'd1,  5'd0,  6'd0,  6'd0}},
    '{32'd68169600,   1'b0, '0},   // leap day in a year divisible by 4
    '{32'd68255999,   1'b0, '0},
    '{32'd951782400,  1'b0, '0},   // leap day in a year divisible by 400
    '{32'd951868800,  1'b0, '0},
    '{32'd978307199,  1'b0, '0},   // last second of a leap year
    '{32'd2147483647, 1'b1, '{12'd2038, MonthJan, 5'd19, 5'd3,  6'd14, 6'd7}},
    '{32'd4107456000, 1'b0, '0},   // end of February in a century non-leap year
    '{32'd4107542400, 1'b0, '0},
    '{32'hAAAAAAAA,   1'b0, '0},
    '{32'h55555555,   1'b0, '0},
    '{32'hFFFFFFFF,   1'b1, '{12'd2106, MonthFeb, 5'd7,  5'd6,  6'd28, 6'd15}}
  };

  // Receiver patterns, each held for a random span of cycles.
  typedef enum logic [1:0] {
    ReadyAlways,
    ReadyCoin,
    ReadySparse,
    ReadyHeld
  } ready_mode_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] seconds_since_epoch;
  logic        out_valid;
  logic        out_ready;
  logic [11:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [4:0]  hour_out;
  logic [5:0]  minute_out;
  logic [5:0]  second_out;

  cal_t pending_dates [$];   // dates owed by the block, oldest first
  cal_t got_date;
  cal_t want_date;
  int   mismatches  = 0;
  int   idle_cycles = 0;
  int   burst_left  = 0;

  unix_seconds_to_calendar_top DUT (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .seconds_since_epoch (seconds_since_epoch),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .year_out            (year_out),
    .month_out           (month_out),
    .day_out             (day_out),
    .hour_out            (hour_out),
    .minute_out          (minute_out),
    .second_out          (second_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit year_is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Date and time of day for a count of seconds since the epoch: whole years
  // are peeled off first, then whole months of the final year.
  function automatic cal_t calendar_of(input logic [31:0] secs);
    int unsigned days;
    int unsigned tod;
    int unsigned year;
    int unsigned month_len;
    int unsigned m;
    bit          leap;
    cal_t        date;
    days = secs / SecsPerDay;
    tod  = secs % SecsPerDay;
    year = EpochYear;
    while (days >= (year_is_leap(year) ? 366 : 365)) begin
      days -= year_is_leap(year) ? 366 : 365;
      year++;
    end
    leap = year_is_leap(year);
    date.month = MonthDec;
    for (m = 0; m < 12; m++) begin
      month_len = DaysInMonth[m] + ((m == 1 && leap) ? 1 : 0);
      if (days < month_len) begin
        date.month = 4'(m + 1);
        break;
      end
      days -= month_len;
    end
    date.year   = 12'(year);
    date.day    = 5'(days + 1);
    date.hour   = 5'(tod / SecsPerHour);
    date.minute = 6'((tod % SecsPerHour) / SecsPerMin);
    date.second = 6'(tod % SecsPerMin);
    return date;
  endfunction

  // Offers one request and waits for it to be taken. The sender runs in bursts;
  // when a burst is used up it drops valid for a random gap first.
  task automatic drive_request(input logic [31:0] secs, input cal_t date);
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 29)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_valid            = 1'b1;
    seconds_since_epoch = secs;
    do @(posedge clk); while (!in_ready);
    pending_dates.push_back(date);
  endtask

  // Holds the sender off until every owed date has come back.
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_dates.size() != 0) @(negedge clk);
  endtask

  // Stimulus: directed table, a full drain, then random requests.
  initial begin
    int unsigned      n;
    int unsigned      y;
    int unsigned      year_pick;
    int unsigned      tod;
    longint unsigned  day_count;
    longint unsigned  t;
    logic [31:0]      secs;
    rst                 = 1'b1;
    in_valid            = 1'b0;
    seconds_since_epoch = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (n = 0; n < NumProbes; n++) begin
      drive_request(Probes[n].secs,
                    Probes[n].known ? Probes[n].date : calendar_of(Probes[n].secs));
    end
    hold_until_drained();

    for (n = 0; n < RandomRequests; n++) begin
      case ($urandom_range(0, 2))
        0:       tod = 0;
        1:       tod = SecsPerDay - 1;
        default: tod = $urandom_range(0, SecsPerDay - 1);
      endcase
      case ($urandom_range(0, 9))
        5, 6: begin
          // the chosen time of day on an arbitrary day
          day_count = 64'($urandom_range(0, 49710));
          t         = day_count * SecsPerDay + tod;
          secs      = t[31:0];
        end
        7: begin
          // close to either end of the input range
          secs = $urandom_range(0, 1) ? 32'($urandom_range(0, 200000))
                                      : 32'hFFFFFFFF - 32'($urandom_range(0, 200000));
        end
        8, 9: begin
          // somewhere within a chosen year, so every month and leap day turn up
          year_pick = $urandom_range(EpochYear, 2106);
          day_count = 0;
          for (y = EpochYear; y < year_pick; y++)
            day_count += 64'(year_is_leap(y) ? 366 : 365);
          day_count += 64'($urandom_range(0, 365));
          t          = day_count * SecsPerDay + tod;
          secs       = t[31:0];
        end
        default: secs = $urandom();
      endcase
      drive_request(secs, calendar_of(secs));
      if (n % 400 == 399) hold_until_drained();
    end

    hold_until_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Receiver: ready follows a pattern that changes every so often, from always
  // ready through to held low for a whole span.
  initial begin
    ready_mode_t ready_mode;
    int          span;
    out_ready = 1'b0;
    forever begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      span       = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        case (ready_mode)
          ReadyAlways: out_ready = 1'b1;
          ReadyCoin:   out_ready = 1'($urandom_range(0, 1));
          ReadySparse: out_ready = ($urandom_range(0, 7) == 0);
          default:     out_ready = 1'b0;
        endcase
      end
    end
  end

  // Result check: each date taken is matched against the oldest one owed.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_date = '{year_out, month_out, day_out, hour_out, minute_out, second_out};
      if (pending_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("%0t: unexpected result %0d-%0d-%0d %0d:%0d:%0d, none owed", $realtime,
                   got_date.year, got_date.month, got_date.day,
                   got_date.hour, got_date.minute, got_date.second);
      end else begin
        want_date = pending_dates.pop_front();
        if (got_date.year   !== want_date.year   || got_date.month  !== want_date.month ||
            got_date.day    !== want_date.day    || got_date.hour   !== want_date.hour  ||
            got_date.minute !== want_date.minute || got_date.second !== want_date.second) begin
          mismatches++;
          if (mismatches <= MaxReported)
            $display("%0t: expected %0d-%0d-%0d %0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d",
                     $realtime,
                     want_date.year, want_date.month, want_date.day,
                     want_date.hour, want_date.minute, want_date.second,
                     got_date.year, got_date.month, got_date.day,
                     got_date.hour, got_date.minute, got_date.second);
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a request or result.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("%0t: watchdog, no handshake for %0d cycles", $realtime, WatchdogLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
